// ----- sv/ctok_pkg.sv -----
`timescale 1ns / 1ps

package ctok_pkg;

    // Token kinds
    localparam logic [4:0] KIND_EOF     = 5'd0;
    localparam logic [4:0] KIND_IDENT   = 5'd1;
    localparam logic [4:0] KIND_INT     = 5'd2;
    localparam logic [4:0] KIND_FLOAT   = 5'd3;
    localparam logic [4:0] KIND_UNKNOWN = 5'd4;
    localparam logic [4:0] KIND_LBRACE  = 5'd5;
    localparam logic [4:0] KIND_RBRACE  = 5'd6;
    localparam logic [4:0] KIND_RPAREN  = 5'd7;
    localparam logic [4:0] KIND_LPAREN  = 5'd8;
    localparam logic [4:0] KIND_SEMI    = 5'd9;
    localparam logic [4:0] KIND_COMMA   = 5'd10;
    localparam logic [4:0] KIND_PLUS    = 5'd11;
    localparam logic [4:0] KIND_MINUS   = 5'd12;
    localparam logic [4:0] KIND_STAR    = 5'd13;
    localparam logic [4:0] KIND_ASSIGN  = 5'd14;
    localparam logic [4:0] KIND_LESS    = 5'd15;
    localparam logic [4:0] KIND_GREATER = 5'd16;
    localparam logic [4:0] KIND_SLASH   = 5'd17;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_SUFFIX   = 2'd1;
    localparam logic [1:0] ERR_UNTERM   = 2'd2;
    localparam logic [1:0] ERR_UNKNOWN  = 2'd3;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Result queue sizing: room for one in-flight item plus one new item
    localparam int Q_DEPTH     = 8;
    localparam int Q_PTR_W     = 3;
    localparam int Q_LVL_W     = 4;
    localparam logic [Q_LVL_W-1:0] Q_READY_LEVEL = 4'd4;

    typedef struct packed {
        logic [7:0] next_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [31:0] token_start;
        logic [7:0]  token_length;
        logic [1:0]  error_code;
        logic        last_of_run;
    } t_out_item;

    // Results of one byte, compacted: item0 first, item1 only when count is 2
    typedef struct packed {
        logic [1:0] count;
        t_out_item  item0;
        t_out_item  item1;
    } t_push;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_FF, CH_VT, CH_CR, CH_LF};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_SEVEN]};
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE], [CH_UP_A:CH_UP_F], [CH_LO_A:CH_LO_F]};
    endfunction

    function automatic logic is_head(input logic [7:0] c);
        return c inside {CH_UNDER, [CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]};
    endfunction

    function automatic logic is_term(input logic [7:0] c);
        return is_space(c) ||
               (c inside {CH_SEMI, CH_COMMA, CH_RPAREN, CH_RBRACK, CH_RBRACE});
    endfunction

    // Single-character punctuator kind, KIND_EOF when not a punctuator
    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            CH_LBRACE:  k = KIND_LBRACE;
            CH_RBRACE:  k = KIND_RBRACE;
            CH_RPAREN:  k = KIND_RPAREN;
            CH_LPAREN:  k = KIND_LPAREN;
            CH_SEMI:    k = KIND_SEMI;
            CH_COMMA:   k = KIND_COMMA;
            CH_PLUS:    k = KIND_PLUS;
            CH_MINUS:   k = KIND_MINUS;
            CH_STAR:    k = KIND_STAR;
            CH_EQUAL:   k = KIND_ASSIGN;
            CH_LESS:    k = KIND_LESS;
            CH_GREATER: k = KIND_GREATER;
            CH_SLASH:   k = KIND_SLASH;
            default:    k = KIND_EOF;
        endcase
        return k;
    endfunction

endpackage

// ----- sv/ctok_lexer.sv -----
`timescale 1ns / 1ps

module ctok_lexer #(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int OFFSET_BITS   = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ctok_pkg::t_in_item i_item,
    output ctok_pkg::t_push   o_push
);
    import ctok_pkg::*;

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);

    typedef enum logic [15:0] {
        M_IDLE   = 16'h0001,
        M_IDENT  = 16'h0002,
        M_SLASH  = 16'h0004,
        M_LINE   = 16'h0008,
        M_BLOCK  = 16'h0010,
        M_STAR   = 16'h0020,
        M_ZERO   = 16'h0040,
        M_HEXP   = 16'h0080,
        M_HEX    = 16'h0100,
        M_OCT    = 16'h0200,
        M_DEC    = 16'h0400,
        M_FRAC   = 16'h0800,
        M_EXPE   = 16'h1000,
        M_EXPS   = 16'h2000,
        M_EXPD   = 16'h4000,
        M_SUFFIX = 16'h8000
    } t_mode;

    t_mode                  r_mode, n_mode;
    logic [LEN_W-1:0]       r_len, n_len;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic                   r_frac, n_frac;
    logic                   r_suf, n_suf;

    // Widened views for truncation to the fixed output widths
    logic [LEN_W+7:0]        len_ext;
    logic [OFFSET_BITS+31:0] start_ext;
    logic [OFFSET_BITS+31:0] pos_ext;

    assign len_ext   = {8'd0, r_len};
    assign start_ext = {32'd0, r_start};
    assign pos_ext   = {32'd0, r_pos};

    always_comb begin
        logic [7:0]  c;
        logic        rescan;
        logic        grow;
        t_mode       grow_mode;
        logic        tail;
        logic        tail_suf;
        logic        pend;
        logic [4:0]  pend_kind;
        logic [1:0]  pend_err;
        logic        second;
        t_out_item   pend_item;
        t_out_item   second_item;
        logic [4:0]  pk;

        c         = i_item.next_byte;
        rescan    = 1'b0;
        grow      = 1'b0;
        grow_mode = M_IDLE;
        tail      = 1'b0;
        tail_suf  = r_suf;
        pend      = 1'b0;
        pend_kind = KIND_EOF;
        pend_err  = ERR_NONE;
        second    = 1'b0;
        pk        = punct_kind(c);

        n_mode  = r_mode;
        n_len   = r_len;
        n_start = r_start;
        n_pos   = r_pos;
        n_frac  = r_frac;
        n_suf   = r_suf;

        second_item = '0;
        second_item.token_start = pos_ext[31:0];

        if (i_valid && (i_item.end_of_text || c == CH_NUL)) begin
            // End of text: flush pending token, then eof
            case (r_mode)
                M_IDENT: begin
                    pend = 1'b1; pend_kind = KIND_IDENT;
                end
                M_SLASH: begin
                    pend = 1'b1; pend_kind = KIND_SLASH;
                end
                M_BLOCK, M_STAR: begin
                    second_item.error_code = ERR_UNTERM;
                end
                M_HEXP: begin
                    pend = 1'b1; pend_kind = KIND_INT; pend_err = ERR_SUFFIX;
                end
                M_EXPE, M_EXPS: begin
                    pend = 1'b1;
                    pend_kind = r_frac ? KIND_FLOAT : KIND_INT;
                    pend_err = ERR_SUFFIX;
                end
                M_ZERO, M_HEX, M_OCT, M_DEC, M_FRAC, M_EXPD, M_SUFFIX: begin
                    pend = 1'b1;
                    pend_kind = r_frac ? KIND_FLOAT : KIND_INT;
                    pend_err = r_suf ? ERR_SUFFIX : ERR_NONE;
                end
                default: begin
                end
            endcase
            second = 1'b1;
            second_item.token_kind = KIND_EOF;
            n_mode  = M_IDLE;
            n_len   = '0;
            n_start = '0;
            n_pos   = '0;
            n_frac  = 1'b0;
            n_suf   = 1'b0;
        end else if (i_valid) begin
            // Continue the pending token
            case (r_mode)
                M_IDLE: rescan = 1'b1;
                M_IDENT: begin
                    if (is_head(c) || is_digit(c)) begin
                        grow = 1'b1; grow_mode = M_IDENT;
                    end else begin
                        pend = 1'b1; pend_kind = KIND_IDENT; rescan = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (c == CH_SLASH) n_mode = M_LINE;
                    else if (c == CH_STAR) n_mode = M_BLOCK;
                    else begin
                        pend = 1'b1; pend_kind = KIND_SLASH; rescan = 1'b1;
                    end
                end
                M_LINE: begin
                    if (c == CH_LF) n_mode = M_IDLE;
                end
                M_BLOCK: begin
                    if (c == CH_STAR) n_mode = M_STAR;
                end
                M_STAR: begin
                    if (c == CH_SLASH) n_mode = M_IDLE;
                    else if (c != CH_STAR) n_mode = M_BLOCK;
                end
                M_ZERO: begin
                    if (c == CH_LO_X || c == CH_UP_X) begin
                        grow = 1'b1; grow_mode = M_HEXP;
                    end else if (is_octal(c)) begin
                        grow = 1'b1; grow_mode = M_OCT;
                    end else if (c == CH_DOT) begin
                        n_frac = 1'b1; grow = 1'b1; grow_mode = M_FRAC;
                    end else tail = 1'b1;
                end
                M_HEXP: begin
                    if (is_hex(c)) begin
                        grow = 1'b1; grow_mode = M_HEX;
                    end else begin
                        pend = 1'b1; pend_kind = KIND_INT; pend_err = ERR_SUFFIX;
                        rescan = 1'b1;
                    end
                end
                M_HEX: begin
                    if (is_hex(c)) begin
                        grow = 1'b1; grow_mode = M_HEX;
                    end else tail = 1'b1;
                end
                M_OCT: begin
                    if (is_octal(c)) begin
                        grow = 1'b1; grow_mode = M_OCT;
                    end else tail = 1'b1;
                end
                M_DEC: begin
                    if (is_digit(c)) begin
                        grow = 1'b1; grow_mode = M_DEC;
                    end else if (c == CH_DOT) begin
                        n_frac = 1'b1; grow = 1'b1; grow_mode = M_FRAC;
                    end else tail = 1'b1;
                end
                M_FRAC: begin
                    if (is_digit(c)) begin
                        grow = 1'b1; grow_mode = M_FRAC;
                    end else if (c == CH_LO_E || c == CH_UP_E) begin
                        grow = 1'b1; grow_mode = M_EXPE;
                    end else tail = 1'b1;
                end
                M_EXPE: begin
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        grow = 1'b1; grow_mode = M_EXPS;
                    end else if (is_digit(c)) begin
                        grow = 1'b1; grow_mode = M_EXPD;
                    end else begin
                        tail = 1'b1; tail_suf = 1'b1; n_suf = 1'b1;
                    end
                end
                M_EXPS: begin
                    if (is_digit(c)) begin
                        grow = 1'b1; grow_mode = M_EXPD;
                    end else begin
                        tail = 1'b1; tail_suf = 1'b1; n_suf = 1'b1;
                    end
                end
                M_EXPD: begin
                    if (is_digit(c)) begin
                        grow = 1'b1; grow_mode = M_EXPD;
                    end else tail = 1'b1;
                end
                M_SUFFIX: tail = 1'b1;
                default: begin
                    n_mode = M_IDLE; rescan = 1'b1;
                end
            endcase

            // Number cannot grow: end at a terminator, else absorb a suffix
            if (tail) begin
                if (is_term(c)) begin
                    pend = 1'b1;
                    pend_kind = r_frac ? KIND_FLOAT : KIND_INT;
                    pend_err = tail_suf ? ERR_SUFFIX : ERR_NONE;
                    rescan = 1'b1;
                end else begin
                    n_suf = 1'b1; grow = 1'b1; grow_mode = M_SUFFIX;
                end
            end

            if (grow) begin
                n_mode = grow_mode;
                if (r_len < LEN_MAX) n_len = r_len + 1'b1;
            end

            if (pend) n_mode = M_IDLE;

            // Scan the byte afresh from idle
            if (rescan && !is_space(c)) begin
                if (is_head(c) || is_digit(c) || c == CH_SLASH) begin
                    n_start = r_pos;
                    n_len   = LEN_W'(1);
                    n_frac  = 1'b0;
                    n_suf   = 1'b0;
                    if (is_head(c)) n_mode = M_IDENT;
                    else if (c == CH_ZERO) n_mode = M_ZERO;
                    else if (is_digit(c)) n_mode = M_DEC;
                    else n_mode = M_SLASH;
                end else begin
                    second = 1'b1;
                    second_item.token_length = 8'd1;
                    if (pk != KIND_EOF) begin
                        second_item.token_kind = pk;
                    end else begin
                        second_item.token_kind = KIND_UNKNOWN;
                        second_item.error_code = ERR_UNKNOWN;
                    end
                end
            end

            n_pos = r_pos + 1'b1;
        end

        pend_item              = '0;
        pend_item.token_kind   = pend_kind;
        pend_item.token_start  = start_ext[31:0];
        pend_item.token_length = len_ext[7:0];
        pend_item.error_code   = pend_err;

        // Compact the results and mark the last one
        o_push = '0;
        if (pend && second) begin
            o_push.count = 2'd2;
            o_push.item0 = pend_item;
            o_push.item1 = second_item;
            o_push.item1.last_of_run = 1'b1;
        end else if (pend) begin
            o_push.count = 2'd1;
            o_push.item0 = pend_item;
            o_push.item0.last_of_run = 1'b1;
        end else if (second) begin
            o_push.count = 2'd1;
            o_push.item0 = second_item;
            o_push.item0.last_of_run = 1'b1;
        end
    end

    // Scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_len   <= '0;
            r_start <= '0;
            r_pos   <= '0;
            r_frac  <= 1'b0;
            r_suf   <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_len   <= n_len;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_frac  <= n_frac;
            r_suf   <= n_suf;
        end
    end

endmodule

// ----- sv/ctok_outq.sv -----
`timescale 1ns / 1ps

module ctok_outq (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ctok_pkg::t_push                  i_push,
    input  logic                             i_pop,
    output logic                             o_valid,
    output ctok_pkg::t_out_item              o_item,
    output logic [ctok_pkg::Q_LVL_W-1:0]     o_level
);
    import ctok_pkg::*;

    t_out_item            r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_LVL_W-1:0]   r_level, n_level;
    logic                 pop;
    logic [Q_PTR_W-1:0]   wr_ptr_1;

    assign o_valid  = (r_level != '0);
    assign o_item   = r_mem[r_rd_ptr];
    assign o_level  = r_level;
    assign pop      = i_pop && o_valid;
    assign wr_ptr_1 = r_wr_ptr + 1'b1;

    // Pointer and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr + Q_PTR_W'(i_push.count);
        n_rd_ptr = r_rd_ptr + Q_PTR_W'(pop);
        n_level  = r_level + Q_LVL_W'(i_push.count) - Q_LVL_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    // Entry storage, up to two writes per cycle
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) r_mem[r_wr_ptr] <= i_push.item0;
        if (i_push.count == 2'd2) r_mem[wr_ptr_1] <= i_push.item1;
    end

endmodule

// ----- sv/c_token_scanner_core.sv -----
`timescale 1ns / 1ps

// Streaming C token scanner. One source byte is accepted per clock while the
// result queue holds four tokens or fewer; each byte yields zero, one or two
// tokens (eof included), and tokens leave at one per clock while the receiver
// is ready, so a byte is taken every cycle unless the receiver stalls or the
// text packs two tokens into one byte faster than the output drains. A byte
// passes an input register, then one pass of scan logic writes its tokens into
// an eight-entry queue, from which the first token of a byte is offered. The
// end of text (flag or a zero byte) flushes the pending token, emits eof and
// restarts offsets at 0.
module c_token_scanner_core #(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int OFFSET_BITS   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ctok_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ctok_pkg::t_out_item  o_out_item
);
    import ctok_pkg::*;

    logic                 r_in_valid;
    t_in_item             r_in_item;
    t_push                push;
    logic [Q_LVL_W-1:0]   level;

    // Room for the item in flight plus one more
    assign o_in_ready = (level <= Q_READY_LEVEL);

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_in_valid && o_in_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_in_item <= i_in_item;
    end

    ctok_lexer #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .OFFSET_BITS   (OFFSET_BITS)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_item  (r_in_item),
        .o_push  (push)
    );

    ctok_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .o_level (level)
    );

endmodule
